// ----- hdl/assert_macros.svh -----
// assertion helper macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on the rising clock, muted while reset is low
`define VML_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same check, but also evaluated while reset is held
`define VML_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/vml_pkg.sv -----
// ----------------------------------------------------------------------------
// vml_pkg
// shared widths, codes and stage payload types of the vector magnitude limiter
// ----------------------------------------------------------------------------
`default_nettype none

package vml_pkg;

  localparam int unsigned DataWidth = 16;
  localparam int unsigned MagWidth  = DataWidth;          // |c| up to 2^(W-1)
  localparam int unsigned SqWidth   = 2 * DataWidth;      // square of a magnitude
  localparam int unsigned SumWidth  = 2 * DataWidth + 1;  // sum of two squares
  localparam int unsigned RootWidth = DataWidth + 1;      // floor(sqrt(sum))
  localparam int unsigned ProdWidth = 2 * DataWidth;      // |c| * L
  localparam int unsigned QuotWidth = DataWidth;          // |c| * L / m < 2^(W-1)+1
  localparam int unsigned TdataInWidth  = 56;
  localparam int unsigned TdataOutWidth = 40;

  typedef enum logic [1:0] {
    ACT_SCALE  = 2'd0,
    ACT_KEEP_X = 2'd1,
    ACT_KEEP_Y = 2'd2,
    ACT_RSVD   = 2'd3
  } action_e;

  typedef logic signed [DataWidth-1:0] data_t;
  typedef logic [MagWidth-1:0]  mag_t;
  typedef logic [SumWidth-1:0]  sum_t;
  typedef logic [RootWidth-1:0] root_t;

  // one bit of a restoring square root; width-generic through the sum type
  typedef struct packed {
    sum_t rem;
    sum_t res;
  } sqrt_st_t;

  // payload handed from the front end to the square-root pipe
  typedef struct packed {
    data_t   x;
    data_t   y;
    mag_t    lim;
    action_e act;
    logic    lim_hit;   // scale mode: sum exceeds limit squared
    sum_t    radicand;
  } front_t;

  // payload handed from the root to the divide pipe
  typedef struct packed {
    data_t   x;
    data_t   y;
    mag_t    lim;
    action_e act;
    logic    lim_hit;
    root_t   root;
  } root_pl_t;

  // final result
  typedef struct packed {
    data_t x;
    data_t y;
    logic  sat;
  } result_t;

  function automatic mag_t abs_of(input data_t v);
    logic [DataWidth-1:0] n;
    n = v[DataWidth-1] ? (~v + 1'b1) : v;
    return mag_t'(n);
  endfunction

  function automatic logic is_scale(input action_e a);
    return (a != ACT_KEEP_X) && (a != ACT_KEEP_Y);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/vml_front.sv -----
// ----------------------------------------------------------------------------
// vml_front
// squares and radicand: two register stages in front of the square root
// ----------------------------------------------------------------------------
`default_nettype none

module vml_front (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    en_i,
  input  wire                    valid_i,
  input  vml_pkg::data_t         x_i,
  input  vml_pkg::data_t         y_i,
  input  vml_pkg::data_t         limit_i,
  input  vml_pkg::action_e       act_i,
  output logic                   valid_o,
  output vml_pkg::front_t        pl_o
);
  import vml_pkg::*;

  typedef struct packed {
    data_t   x;
    data_t   y;
    mag_t    lim;
    action_e act;
    logic [SqWidth-1:0] sq_x;
    logic [SqWidth-1:0] sq_y;
    logic [SqWidth-1:0] sq_l;
  } sq_t;

  sq_t  sq_d, sq_q;
  logic v1_q;
  front_t fr_d, fr_q;
  logic v2_q;
  mag_t ax, ay;

  // stage 1: three squares
  always_comb begin
    ax = abs_of(x_i);
    ay = abs_of(y_i);
    sq_d.x    = x_i;
    sq_d.y    = y_i;
    sq_d.lim  = abs_of(limit_i);
    sq_d.act  = act_i;
    sq_d.sq_x = SqWidth'(ax) * SqWidth'(ax);
    sq_d.sq_y = SqWidth'(ay) * SqWidth'(ay);
    sq_d.sq_l = SqWidth'(sq_d.lim) * SqWidth'(sq_d.lim);
  end

  // stage 2: sum or difference and compare
  always_comb begin
    logic [SqWidth-1:0] kept;
    sum_t s;
    kept = (sq_q.act == ACT_KEEP_X) ? sq_q.sq_x : sq_q.sq_y;
    s    = SumWidth'(sq_q.sq_x) + SumWidth'(sq_q.sq_y);
    fr_d.x   = sq_q.x;
    fr_d.y   = sq_q.y;
    fr_d.lim = sq_q.lim;
    fr_d.act = sq_q.act;
    if (is_scale(sq_q.act)) begin
      fr_d.lim_hit  = s > SumWidth'(sq_q.sq_l);
      fr_d.radicand = s;
    end else begin
      fr_d.lim_hit  = 1'b0;
      fr_d.radicand = (kept > sq_q.sq_l) ? '0 : SumWidth'(sq_q.sq_l - kept);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
      fr_q <= fr_d;
    end
  end

  assign valid_o = v2_q;
  assign pl_o    = fr_q;

endmodule

`default_nettype wire

// ----- hdl/vml_sqrt.sv -----
// ----------------------------------------------------------------------------
// vml_sqrt
// pipelined restoring square root, one result bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module vml_sqrt (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    en_i,
  input  wire                    valid_i,
  input  vml_pkg::front_t        pl_i,
  output logic                   valid_o,
  output vml_pkg::root_pl_t      pl_o
);
  import vml_pkg::*;

  localparam int unsigned Steps = RootWidth;

  typedef struct packed {
    data_t   x;
    data_t   y;
    mag_t    lim;
    action_e act;
    logic    lim_hit;
    sum_t    rem;
    sum_t    res;
    sum_t    bitv;
  } st_t;

  st_t  st_q [Steps];
  st_t  st_d [Steps];
  logic [Steps-1:0] v_q;
  st_t  first;

  always_comb begin
    first.x       = pl_i.x;
    first.y       = pl_i.y;
    first.lim     = pl_i.lim;
    first.act     = pl_i.act;
    first.lim_hit = pl_i.lim_hit;
    first.rem     = pl_i.radicand;
    first.res     = '0;
    first.bitv    = sum_t'(1) << (2 * (Steps - 1));
  end

  always_comb begin
    st_t cur;
    for (int i = 0; i < Steps; i++) begin
      cur = (i == 0) ? first : st_q[(i == 0) ? 0 : i - 1];
      st_d[i] = cur;
      if (cur.rem >= cur.res + cur.bitv) begin
        st_d[i].rem = cur.rem - (cur.res + cur.bitv);
        st_d[i].res = (cur.res >> 1) + cur.bitv;
      end else begin
        st_d[i].res = cur.res >> 1;
      end
      st_d[i].bitv = cur.bitv >> 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Steps-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < Steps; i++) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  assign valid_o      = v_q[Steps-1];
  assign pl_o.x       = st_q[Steps-1].x;
  assign pl_o.y       = st_q[Steps-1].y;
  assign pl_o.lim     = st_q[Steps-1].lim;
  assign pl_o.act     = st_q[Steps-1].act;
  assign pl_o.lim_hit = st_q[Steps-1].lim_hit;
  assign pl_o.root    = root_t'(st_q[Steps-1].res);

endmodule

`default_nettype wire

// ----- hdl/vml_scale.sv -----
// ----------------------------------------------------------------------------
// vml_scale
// product |c|*L, pipelined restoring divide by the root, clamp and sign
// ----------------------------------------------------------------------------
`default_nettype none

module vml_scale (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    en_i,
  input  wire                    valid_i,
  input  vml_pkg::root_pl_t      pl_i,
  output logic                   valid_o,
  output vml_pkg::result_t       res_o
);
  import vml_pkg::*;

  localparam int unsigned Steps = QuotWidth;
  localparam int unsigned RemWidth = RootWidth + 1;

  typedef struct packed {
    data_t   x;
    data_t   y;
    action_e act;
    logic    lim_hit;
    root_t   root;
    logic [ProdWidth-1:0] px;   // dividend shifts out at the top
    logic [ProdWidth-1:0] py;
    logic [RemWidth-1:0]  rx;
    logic [RemWidth-1:0]  ry;
  } st_t;

  st_t  p_d, p_q;
  logic pv_q;
  st_t  st_q [Steps];
  st_t  st_d [Steps];
  logic [Steps-1:0] v_q;
  result_t res_d, res_q;
  logic rv_q;

  // product stage
  always_comb begin
    p_d.x       = pl_i.x;
    p_d.y       = pl_i.y;
    p_d.act     = pl_i.act;
    p_d.lim_hit = pl_i.lim_hit;
    // clamp modes need the bare root as bound; a limited vector has a root of
    // at least one, so the divisor is never zero where the quotient is used
    p_d.root    = pl_i.root;
    p_d.px      = ProdWidth'(abs_of(pl_i.x)) * ProdWidth'(pl_i.lim);
    p_d.py      = ProdWidth'(abs_of(pl_i.y)) * ProdWidth'(pl_i.lim);
    p_d.rx      = '0;
    p_d.ry      = '0;
    // quotient < 2^Steps, so the top bits of the product start in the remainder
    p_d.rx      = RemWidth'(p_d.px >> Steps);
    p_d.ry      = RemWidth'(p_d.py >> Steps);
    p_d.px      = p_d.px << (ProdWidth - Steps);
    p_d.py      = p_d.py << (ProdWidth - Steps);
  end

  // one quotient bit per stage; quotient bits shift in at the bottom of px/py
  always_comb begin
    st_t cur;
    logic [RemWidth-1:0] tx, ty;
    for (int i = 0; i < Steps; i++) begin
      cur = (i == 0) ? p_q : st_q[(i == 0) ? 0 : i - 1];
      st_d[i] = cur;
      tx = {cur.rx[RemWidth-2:0], cur.px[ProdWidth-1]};
      ty = {cur.ry[RemWidth-2:0], cur.py[ProdWidth-1]};
      if (tx >= RemWidth'(cur.root)) begin
        st_d[i].rx = tx - RemWidth'(cur.root);
        st_d[i].px = {cur.px[ProdWidth-2:0], 1'b1};
      end else begin
        st_d[i].rx = tx;
        st_d[i].px = {cur.px[ProdWidth-2:0], 1'b0};
      end
      if (ty >= RemWidth'(cur.root)) begin
        st_d[i].ry = ty - RemWidth'(cur.root);
        st_d[i].py = {cur.py[ProdWidth-2:0], 1'b1};
      end else begin
        st_d[i].ry = ty;
        st_d[i].py = {cur.py[ProdWidth-2:0], 1'b0};
      end
    end
  end

  // output stage: clamp modes use the root as bound, scale mode the quotients
  always_comb begin
    st_t f;
    logic [QuotWidth-1:0] qx, qy;
    logic [RootWidth:0] bx, by;
    data_t xo, yo;
    f  = st_q[Steps-1];
    qx = QuotWidth'(f.px);
    qy = QuotWidth'(f.py);
    xo = f.x;
    yo = f.y;
    bx = {1'b0, f.root};
    by = {1'b0, f.root};
    unique case (f.act)
      ACT_KEEP_X: begin
        if ($signed({f.y[DataWidth-1], f.y}) > $signed({1'b0, bx})) begin
          yo = data_t'(f.root);
        end else if ($signed({f.y[DataWidth-1], f.y}) < -$signed({1'b0, by})) begin
          yo = data_t'(-$signed({1'b0, f.root}));
        end
      end
      ACT_KEEP_Y: begin
        if ($signed({f.x[DataWidth-1], f.x}) > $signed({1'b0, bx})) begin
          xo = data_t'(f.root);
        end else if ($signed({f.x[DataWidth-1], f.x}) < -$signed({1'b0, by})) begin
          xo = data_t'(-$signed({1'b0, f.root}));
        end
      end
      default: begin
        if (f.lim_hit) begin
          xo = f.x[DataWidth-1] ? data_t'(-qx) : data_t'(qx);
          yo = f.y[DataWidth-1] ? data_t'(-qy) : data_t'(qy);
        end
      end
    endcase
    res_d.x   = xo;
    res_d.y   = yo;
    res_d.sat = (xo != f.x) || (yo != f.y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      v_q  <= '0;
      rv_q <= 1'b0;
    end else if (en_i) begin
      pv_q <= valid_i;
      v_q  <= {v_q[Steps-2:0], pv_q};
      rv_q <= v_q[Steps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
      for (int i = 0; i < Steps; i++) begin
        st_q[i] <= st_d[i];
      end
      res_q <= res_d;
    end
  end

  assign valid_o = rv_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ----- hdl/vector_magnitude_limiter.sv -----
// ----------------------------------------------------------------------------
// vector_magnitude_limiter
// limits a two-dimensional vector to a circle of per-transaction radius
// ----------------------------------------------------------------------------
// Takes one vector per cycle and returns one result per transaction in order.
// action 0 (and the unused code 3) scales both components by |limit|/|v| when
// |v| exceeds |limit|, truncating toward zero; action 1 keeps x and clamps y to
// +-floor(sqrt(limit^2 - x^2)); action 2 keeps y and clamps x likewise, with a
// negative radicand taken as zero. saturated is set when either component
// changed. The pipe holds two stages of squares and radicand, a 17-stage
// bit-per-stage square root, a product stage, a 16-stage bit-per-stage divider
// and an output register. Throughput is one transaction per cycle; the whole
// pipe advances together whenever the output register is empty or being taken,
// so m_axis_tready low stalls the pipe.
`default_nettype none

module vector_magnitude_limiter (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // x_in [15:0], y_in [31:16], limit [47:32], action [49:48], zeros above
  input  wire  [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // x_out [15:0], y_out [31:16], saturated [32], zeros above
  output logic [39:0] m_axis_tdata
);
  import vml_pkg::*;

  logic       en;
  logic       fr_v, rt_v, sc_v;
  front_t     fr_pl;
  root_pl_t   rt_pl;
  result_t    res;

  // pipe advances when the output slot is free or drained this cycle
  assign en            = !sc_v || m_axis_tready;
  assign s_axis_tready = en;

  vml_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .x_i     (data_t'(s_axis_tdata[15:0])),
    .y_i     (data_t'(s_axis_tdata[31:16])),
    .limit_i (data_t'(s_axis_tdata[47:32])),
    .act_i   (action_e'(s_axis_tdata[49:48])),
    .valid_o (fr_v),
    .pl_o    (fr_pl)
  );

  vml_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .pl_i    (fr_pl),
    .valid_o (rt_v),
    .pl_o    (rt_pl)
  );

  vml_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rt_v),
    .pl_i    (rt_pl),
    .valid_o (sc_v),
    .res_o   (res)
  );

  assign m_axis_tvalid = sc_v;
  assign m_axis_tdata  = {7'd0, res.sat, res.y, res.x};

endmodule

`default_nettype wire

// ----- hdl/vml_checker.sv -----
// ----------------------------------------------------------------------------
// vml_checker
// port-level checks of the vector magnitude limiter
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module vml_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [39:0] m_axis_tdata
);

  `VML_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
    "stalled result changed")
  `VML_ASSERT(a_ready_stall, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready,
    "input taken while output stalled")
  `VML_ASSERT(a_ready_free, clk_i, rst_ni,
    !m_axis_tvalid |-> s_axis_tready,
    "input refused while pipe free")
  `VML_ASSERT(a_pad_zero, clk_i, rst_ni,
    m_axis_tdata[39:33] == 7'd0,
    "output padding not zero")
  `VML_ASSERT_ALWAYS(a_reset_idle, clk_i,
    !rst_ni |=> !m_axis_tvalid || rst_ni,
    "result valid during reset")

endmodule

bind vector_magnitude_limiter vml_checker u_vml_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- tb/vector_magnitude_limiter_test.sv -----
// ----------------------------------------------------------------------------
// vector_magnitude_limiter_test
// self-checking testbench of the vector magnitude limiter
// ----------------------------------------------------------------------------
// Drives vectors over the slave stream, predicts each result with an exact
// integer model of the limiting modes and checks the master stream in order.
// A directed set of corner vectors comes first, then random vectors under
// several idling phases on both sides.
module vector_magnitude_limiter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import vml_pkg::*;

  localparam int CycleLimit = 400000;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        sat;
  } limited_t;

  // exact integer square root
  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  // expected result of one vector
  function automatic limited_t limit_vector(input data_t x, input data_t y,
                                            input data_t lim, input action_e act);
    longint sx, sy, xo, yo, kept, hi;
    longint unsigned l, l2, k2, r, b, s, m;
    limited_t res;
    sx = x; sy = y;
    l = (lim < 0) ? -longint'(lim) : longint'(lim);
    l2 = l * l;
    xo = sx; yo = sy;
    if (act == ACT_KEEP_X || act == ACT_KEEP_Y) begin
      kept = (act == ACT_KEEP_X) ? sx : sy;
      if (kept < 0) kept = -kept;
      k2 = kept * kept;
      // negative radicand clamps the other component to zero
      r = (k2 > l2) ? 0 : l2 - k2;
      b = isqrt(r);
      hi = longint'(b);
      if (act == ACT_KEEP_X) yo = (sy > hi) ? hi : (sy < -hi) ? -hi : sy;
      else xo = (sx > hi) ? hi : (sx < -hi) ? -hi : sx;
    end else begin
      s = sx * sx + sy * sy;
      if (s > l2) begin
        m = isqrt(s);
        if (m == 0) m = 1;
        xo = ((sx < 0 ? -sx : sx) * l) / m;
        if (sx < 0) xo = -xo;
        yo = ((sy < 0 ? -sy : sy) * l) / m;
        if (sy < 0) yo = -yo;
      end
    end
    res.x = xo[15:0];
    res.y = yo[15:0];
    res.sat = (xo != sx) || (yo != sy);
    return res;
  endfunction

  class limit_scoreboard;
    limited_t pending[$];
    int errors;
    function void note_vector(data_t x, data_t y, data_t lim, action_e act);
      pending.push_back(limit_vector(x, y, lim, act));
    endfunction
    function void check_result(logic [39:0] d);
      limited_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", d);
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.x || d[31:16] !== e.y || d[32] !== e.sat || d[39:33] !== 0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected x=%h y=%h sat=%b, got x=%h y=%h sat=%b",
                   e.x, e.y, e.sat, d[15:0], d[31:16], d[32]);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  // x_in [15:0], y_in [31:16], limit [47:32], action [49:48], zeros above
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  // x_out [15:0], y_out [31:16], saturated [32], zeros above
  logic [39:0] m_axis_tdata;

  limit_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;

  vector_magnitude_limiter dut (.*);

  initial forever #5 clk_i = ~clk_i;

  // cycle guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: stall at random, check on each accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end
  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // one input transaction, with optional idle cycles before it
  task automatic send_vector(input data_t x, input data_t y, input data_t lim,
                             input action_e act);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'd0, act, lim, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_vector(x, y, lim, act);
    @(negedge clk_i);
  endtask

  task automatic send_random(input int n);
    data_t x, y, lim;
    action_e act;
    repeat (n) begin
      x = data_t'($urandom); y = data_t'($urandom);
      // one draw in four keeps the radius to at most 16384 so that limiting happens often
      case ($urandom_range(3))
        0: lim = data_t'($urandom);
        1: lim = data_t'($urandom_range(16384));
        2: lim = data_t'($urandom_range(32767));
        default: lim = -data_t'($urandom_range(32768));
      endcase
      if ($urandom_range(7) == 0) begin
        x = x >>> $urandom_range(15);
        y = y >>> $urandom_range(15);
      end
      act = action_e'($urandom_range(3));
      send_vector(x, y, lim, act);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // corner vectors
    send_vector(16'sh7fff, 16'sh7fff, 16'sh7fff, ACT_SCALE);
    send_vector(16'sh8000, 16'sh8000, 16'sh8000, ACT_SCALE);
    send_vector(16'sh8000, 16'sh7fff, 16'sh0001, ACT_SCALE);
    send_vector('0, '0, '0, ACT_SCALE);          // zero vector passes
    send_vector(16'sh0001, '0, '0, ACT_SCALE);
    send_vector(16'sh4000, 16'shc000, 16'sh2000, ACT_RSVD);
    send_vector(16'sh7fff, 16'sh7fff, 16'sh4000, ACT_KEEP_X); // negative radicand
    send_vector(16'sh8000, 16'sh8000, 16'sh8000, ACT_KEEP_X);
    send_vector(16'sh1000, 16'sh8000, 16'sh7fff, ACT_KEEP_X);
    send_vector(16'sh7fff, 16'sh4000, 16'sh4000, ACT_KEEP_Y);
    send_vector(16'sh8000, 16'sh8000, 16'sh8000, ACT_KEEP_Y);
    send_vector(16'sh8000, 16'sh1000, 16'sh7fff, ACT_KEEP_Y);
    send_vector(16'sh0003, 16'sh0004, 16'sh0005, ACT_SCALE);
    send_vector(16'sh0003, 16'sh0004, 16'shfffc, ACT_SCALE);
    send_vector(16'shffff, 16'shffff, 16'sh0000, ACT_KEEP_Y);
    // idling phases
    send_random(400);
    send_idle_pct = 72;
    send_random(300);
    drain();                                     // pause until all results are back
    send_idle_pct = 0; recv_stall_pct = 72;
    send_random(400);
    send_idle_pct = 38; recv_stall_pct = 38;
    send_random(400);
    send_idle_pct = 0; recv_stall_pct = 0;
    send_random(200);
    drain();
    repeat (60) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/vml_pkg.sv
hdl/vml_front.sv
hdl/vml_sqrt.sv
hdl/vml_scale.sv
hdl/vector_magnitude_limiter.sv
hdl/vml_checker.sv
tb/vector_magnitude_limiter_test.sv
